FILE: sv/lphi_pkg.sv
// Shared types, constants and hash function for the linear probe hash insert core.
package lphi_pkg;

  localparam int MAX_POWER     = 10;
  localparam int KEY_BITS      = 32;
  localparam int SLOT_W        = KEY_BITS + 1;
  localparam int IDX_W         = MAX_POWER;
  localparam int CNT_W         = MAX_POWER + 1;
  localparam int PW_W          = 4;
  localparam int THR_W         = 9;
  localparam int BANK_DEPTH    = 1 << MAX_POWER;
  localparam int FILL_FRAC     = 8;

  localparam logic [PW_W-1:0]  DEFAULT_POWER = PW_W'(4);
  localparam logic [THR_W-1:0] DEFAULT_THR   = THR_W'(154);
  localparam logic [THR_W-1:0] THR_ONE       = THR_W'(256);

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_REINIT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INITIAL_POWER  = 2'd0;
  localparam logic [1:0] CFG_FILL_THRESHOLD = 2'd1;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  key;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic [CNT_W-1:0] entry_count;
    logic [PW_W-1:0]  tbl_power;
  } out_beat_t;

  // Top power bits of sext(key) * (2^61 + 1) mod 2^64.
  // The product is sext(key) + (key << 61): only bits 63:61 see the add.
  function automatic logic [IDX_W-1:0] hash_slot(input logic [KEY_BITS-1:0] k,
                                                 input logic [PW_W-1:0] power);
    logic [63:0]       sx;
    logic [2:0]        top3;
    logic [63:0]       h;
    logic [IDX_W-1:0]  top;
    sx   = 64'(signed'(k));
    top3 = sx[63:61] + k[2:0];
    h    = {top3, sx[60:0]};
    top  = h[63 -: IDX_W];
    return top >> (PW_W'(MAX_POWER) - power);
  endfunction

endpackage

FILE: sv/lphi_ram.sv
// Generic single-port synchronous RAM with registered read.
module lphi_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: sv/linear_probe_hash_insert_core.sv
// Top level: hash set insert engine with two slot banks and a probe/rehash sequencer.
//
// Usage: the in_ channel takes one request beat (insert key, clear, reinit);
// every request yields exactly one out_ beat with status, slot, count and
// current table power. Registers are written through cfg_we/cfg_index/cfg_wdata.
// One request is worked at a time. Each probe step reads the slot RAM and then
// compares the slot. After each result the sequencer returns to idle before
// the next beat is taken. Growth clears the new bank at its new size (one
// slot a cycle), then rehashes the old bank: each old slot is read and checked,
// each live key is probed into the new bank, then the request's key is re-probed.
// Clear and reinit sweep 1024 slots, one per cycle, in both banks at once.
// After reset a clearing pass over all 1024 slots runs with in_ready low; cfg
// writes are taken as ever. A finished result is held in the output register;
// while the receiver stalls the sequencer waits with the next result in hand,
// and a new request is taken as soon as the sequencer is idle.
module linear_probe_hash_insert_core
  import lphi_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_beat_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_beat_t       out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [THR_W-1:0] cfg_wdata
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SWEEP = 9'b000000010,
    S_PRD   = 9'b000000100,
    S_PCHK  = 9'b000001000,
    S_FILL  = 9'b000010000,
    S_GCLR  = 9'b000100000,
    S_GRD   = 9'b001000000,
    S_GCHK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam int OF_W = CNT_W + THR_W + 1;

  state_t              state_r, state_nxt;
  logic [PW_W-1:0]     ip_r, ip_nxt;
  logic [THR_W-1:0]    ft_r, ft_nxt;
  logic [PW_W-1:0]     p_r, p_nxt;
  logic                bank_r, bank_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [SLOT_W-1:0]   rh_r, rh_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    swp_r, swp_nxt;
  logic                mode_r, mode_nxt;
  logic                reply_r, reply_nxt;
  logic                rdbank_r, rdbank_nxt;
  logic [1:0]          rst_r, rst_nxt;
  logic [IDX_W-1:0]    rsl_r, rsl_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;

  logic [IDX_W-1:0]    ram_addr;
  logic                we0, we1;
  logic [SLOT_W-1:0]   ram_wdata, rd0, rd1, rd;
  logic [CNT_W-1:0]    size, half_size;
  logic [IDX_W-1:0]    mask;
  logic [KEY_BITS-1:0] pkey;
  logic [THR_W-1:0]    thr;
  logic                over;
  logic [PW_W-1:0]     reinit_pw;

  lphi_ram #(.WIDTH(SLOT_W), .DEPTH(BANK_DEPTH)) u_bank0 (
    .clk(clk), .we(we0), .addr(ram_addr), .wdata(ram_wdata), .rdata(rd0)
  );
  lphi_ram #(.WIDTH(SLOT_W), .DEPTH(BANK_DEPTH)) u_bank1 (
    .clk(clk), .we(we1), .addr(ram_addr), .wdata(ram_wdata), .rdata(rd1)
  );

  // sizes, probe key and fill check
  always_comb begin
    size      = CNT_W'(1) << p_r;
    half_size = CNT_W'(1) << (p_r - PW_W'(1));
    mask      = IDX_W'(size - CNT_W'(1));
    rd        = rdbank_r ? rd1 : rd0;
    pkey      = mode_r ? rh_r[KEY_BITS-1:0] : key_r;
    thr       = (ft_r > THR_ONE) ? THR_ONE : ft_r;
    over      = ((OF_W'(cnt_r) + OF_W'(1)) << FILL_FRAC) >= (OF_W'(thr) << p_r);
    if (ip_r == PW_W'(0)) begin
      reinit_pw = DEFAULT_POWER;
    end else if (ip_r > PW_W'(MAX_POWER)) begin
      reinit_pw = PW_W'(MAX_POWER);
    end else begin
      reinit_pw = ip_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ip_nxt        = ip_r;
    ft_nxt        = ft_r;
    p_nxt         = p_r;
    bank_nxt      = bank_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    rh_nxt        = rh_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    swp_nxt       = swp_r;
    mode_nxt      = mode_r;
    reply_nxt     = reply_r;
    rdbank_nxt    = rdbank_r;
    rst_nxt       = rst_r;
    rsl_nxt       = rsl_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_addr      = idx_r;
    we0           = 1'b0;
    we1           = 1'b0;
    ram_wdata     = '0;
    in_ready      = (state_r == S_IDLE);

    // config writes
    if (cfg_we) begin
      if (cfg_index == CFG_INITIAL_POWER) begin
        ip_nxt = cfg_wdata[PW_W-1:0];
      end else if (cfg_index == CFG_FILL_THRESHOLD) begin
        ft_nxt = cfg_wdata;
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rst_nxt = ST_OK;
          rsl_nxt = '0;
          case (in_data.req_type)
            REQ_INSERT: begin
              key_nxt   = in_data.key[KEY_BITS-1:0];
              idx_nxt   = hash_slot(in_data.key[KEY_BITS-1:0], p_r);
              n_nxt     = '0;
              mode_nxt  = 1'b0;
              state_nxt = S_PRD;
            end
            REQ_CLEAR: begin
              cnt_nxt   = '0;
              swp_nxt   = '0;
              reply_nxt = 1'b1;
              state_nxt = S_SWEEP;
            end
            REQ_REINIT: begin
              p_nxt     = reinit_pw;
              bank_nxt  = 1'b0;
              cnt_nxt   = '0;
              swp_nxt   = '0;
              reply_nxt = 1'b1;
              state_nxt = S_SWEEP;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // empty both banks
      S_SWEEP: begin
        ram_addr = swp_r[IDX_W-1:0];
        we0      = 1'b1;
        we1      = 1'b1;
        swp_nxt  = swp_r + CNT_W'(1);
        if (swp_r == CNT_W'(BANK_DEPTH - 1)) begin
          state_nxt = reply_r ? S_DONE : S_IDLE;
        end
      end
      S_PRD: begin
        rdbank_nxt = mode_r ? ~bank_r : bank_r;
        state_nxt  = S_PCHK;
      end
      S_PCHK: begin
        if (!rd[KEY_BITS]) begin
          if (mode_r) begin
            ram_wdata = rh_r;
            we0       = bank_r;
            we1       = ~bank_r;
          end else begin
            state_nxt = S_FILL;
          end
        end else if (rd[KEY_BITS-1:0] == pkey) begin
          if (!mode_r) begin
            rst_nxt   = ST_DUP;
            rsl_nxt   = idx_r;
            state_nxt = S_DONE;
          end
        end else if (n_r + CNT_W'(1) == size) begin
          if (!mode_r) begin
            rst_nxt   = ST_FULL;
            rsl_nxt   = '0;
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt   = (idx_r + IDX_W'(1)) & mask;
          n_nxt     = n_r + CNT_W'(1);
          state_nxt = S_PRD;
        end
      end
      // key absent and an empty slot found
      S_FILL: begin
        if (!over) begin
          ram_wdata = {1'b1, key_r};
          we0       = ~bank_r;
          we1       = bank_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          rst_nxt   = ST_OK;
          rsl_nxt   = idx_r;
          state_nxt = S_DONE;
        end else if (p_r < PW_W'(MAX_POWER)) begin
          p_nxt     = p_r + PW_W'(1);
          swp_nxt   = '0;
          mode_nxt  = 1'b1;
          state_nxt = S_GCLR;
        end else begin
          rst_nxt   = ST_FULL;
          rsl_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      // empty the new bank at its new size
      S_GCLR: begin
        ram_addr = swp_r[IDX_W-1:0];
        we0      = bank_r;
        we1      = ~bank_r;
        swp_nxt  = swp_r + CNT_W'(1);
        if (swp_r == size - CNT_W'(1)) begin
          i_nxt     = '0;
          state_nxt = S_GRD;
        end
      end
      S_GRD: begin
        ram_addr   = i_r[IDX_W-1:0];
        rdbank_nxt = bank_r;
        state_nxt  = S_GCHK;
      end
      S_GCHK: begin
        if (rd[KEY_BITS]) begin
          rh_nxt    = rd;
          idx_nxt   = hash_slot(rd[KEY_BITS-1:0], p_r);
          n_nxt     = '0;
          state_nxt = S_PRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = rst_r;
          out_data_nxt.slot_index  = rsl_r;
          out_data_nxt.entry_count = cnt_r;
          out_data_nxt.tbl_power   = p_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // advance the rehash walk once the current old slot is dealt with
    if (mode_r && ((state_r == S_GCHK && !rd[KEY_BITS]) ||
                   (state_r == S_PCHK && (!rd[KEY_BITS] || rd[KEY_BITS-1:0] == pkey ||
                                          n_r + CNT_W'(1) == size)))) begin
      if (i_r + CNT_W'(1) == half_size) begin
        bank_nxt  = ~bank_r;
        mode_nxt  = 1'b0;
        idx_nxt   = hash_slot(key_r, p_r);
        n_nxt     = '0;
        state_nxt = S_PRD;
      end else begin
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_GRD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      ip_r        <= DEFAULT_POWER;
      ft_r        <= DEFAULT_THR;
      p_r         <= DEFAULT_POWER;
      bank_r      <= 1'b0;
      cnt_r       <= '0;
      swp_r       <= '0;
      mode_r      <= 1'b0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ip_r        <= ip_nxt;
      ft_r        <= ft_nxt;
      p_r         <= p_nxt;
      bank_r      <= bank_nxt;
      cnt_r       <= cnt_nxt;
      swp_r       <= swp_nxt;
      mode_r      <= mode_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    rh_r       <= rh_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    rdbank_r   <= rdbank_nxt;
    rst_r      <= rst_nxt;
    rsl_r      <= rsl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // growth rule keeps at least one slot empty
  a_count_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < size) else $error("entry count reached table size");

  // table power stays within its range
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_r >= PW_W'(1) && p_r <= PW_W'(MAX_POWER)) else $error("table power out of range");

  // a result is only loaded from the result state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE) else $error("result without done");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the linear probe hash insert core.
module tb_top;
  import lphi_pkg::*;

  localparam int LIMIT = 1000000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_beat_t        out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [THR_W-1:0] cfg_wdata;

  linear_probe_hash_insert_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow of the hash set
  logic [32:0] shadow_slots [0:2*BANK_DEPTH-1];
  int          shadow_bank;
  int          shadow_power;
  int          shadow_count;
  int          shadow_init_pw;
  int          shadow_thr;

  in_beat_t  req_fifo [$];
  out_beat_t expected_beats [$];
  int        n_queued;
  int        n_taken;
  int        errors;
  int        cycles;
  int        snd_idle;
  int        rcv_idle;
  logic      taken;
  logic [31:0] key_pool [0:15];

  function automatic int home_slot(logic [31:0] k, int p);
    logic [63:0] x;
    logic [63:0] h;
    x = {{32{k[31]}}, k};
    h = x + (x << 61);
    return int'(h >> (64 - p));
  endfunction

  // 0 empty found, 1 present, 2 no room
  function automatic int find_slot(int bank, int p, logic [31:0] k, output int s);
    int sz;
    int idx;
    logic [32:0] e;
    sz = 1 << p;
    idx = home_slot(k, p) & (sz - 1);
    for (int n = 0; n < sz; n++) begin
      e = shadow_slots[bank * BANK_DEPTH + idx];
      if (!e[32]) begin
        s = idx;
        return 0;
      end
      if (e[31:0] == k) begin
        s = idx;
        return 1;
      end
      idx = (idx + 1) & (sz - 1);
    end
    s = 0;
    return 2;
  endfunction

  function automatic void wipe_bank(int bank);
    for (int i = 0; i < BANK_DEPTH; i++) shadow_slots[bank * BANK_DEPTH + i] = '0;
  endfunction

  function automatic void double_table();
    int ob;
    int nb;
    int osz;
    int s;
    logic [32:0] e;
    ob = shadow_bank;
    nb = ob ^ 1;
    osz = 1 << shadow_power;
    wipe_bank(nb);
    shadow_power++;
    for (int i = 0; i < osz; i++) begin
      e = shadow_slots[ob * BANK_DEPTH + i];
      if (e[32] && find_slot(nb, shadow_power, e[31:0], s) == 0)
        shadow_slots[nb * BANK_DEPTH + s] = e;
    end
    shadow_bank = nb;
  endfunction

  function automatic bit too_full();
    longint thr;
    thr = shadow_thr > 256 ? 256 : shadow_thr;
    return (longint'(shadow_count) + 1) * 256 >= thr * (longint'(1) << shadow_power);
  endfunction

  // expected answer for one request, updating the shadow
  function automatic out_beat_t insert_answer(in_beat_t b);
    out_beat_t o;
    int r;
    int s;
    logic [1:0] st;
    st = ST_OK;
    s = 0;
    if (b.req_type == REQ_INSERT) begin
      r = find_slot(shadow_bank, shadow_power, b.key, s);
      if (r == 1) st = ST_DUP;
      else if (r == 2) begin
        st = ST_FULL;
        s = 0;
      end else begin
        if (too_full()) begin
          while (too_full() && shadow_power < MAX_POWER) double_table();
          if (too_full()) r = 2;
          else r = find_slot(shadow_bank, shadow_power, b.key, s);
        end
        if (r != 0) begin
          st = ST_FULL;
          s = 0;
        end else begin
          shadow_slots[shadow_bank * BANK_DEPTH + s] = {1'b1, b.key};
          shadow_count++;
        end
      end
    end else if (b.req_type == REQ_CLEAR) begin
      wipe_bank(0);
      wipe_bank(1);
      shadow_count = 0;
    end else if (b.req_type == REQ_REINIT) begin
      shadow_power = shadow_init_pw == 0 ? 4 :
                     (shadow_init_pw > MAX_POWER ? MAX_POWER : shadow_init_pw);
      wipe_bank(0);
      wipe_bank(1);
      shadow_bank = 0;
      shadow_count = 0;
    end
    o.status = st;
    o.slot_index = IDX_W'(s);
    o.entry_count = CNT_W'(shadow_count);
    o.tbl_power = PW_W'(shadow_power);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) in_valid <= 1'b0;
    else if (in_valid && !taken) in_valid <= 1'b1;
    else if (req_fifo.size() > 0 && $urandom_range(99) >= snd_idle) begin
      in_valid <= 1'b1;
      in_data <= req_fifo.pop_front();
    end else in_valid <= 1'b0;
    out_ready <= $urandom_range(99) >= rcv_idle;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    out_beat_t want;
    taken <= in_valid && in_ready && rst_n;
    if (rst_n) begin
      cycles++;
      if (cycles > LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected result beats", 1, 0);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.slot_index != want.slot_index)
            report_mismatch("slot_index", out_data.slot_index, want.slot_index);
          if (out_data.entry_count != want.entry_count)
            report_mismatch("entry_count", out_data.entry_count, want.entry_count);
          if (out_data.tbl_power != want.tbl_power)
            report_mismatch("tbl_power", out_data.tbl_power, want.tbl_power);
        end
      end
      if (in_valid && in_ready) begin
        expected_beats.push_back(insert_answer(in_data));
        n_taken++;
      end
    end
  end

  task automatic push_req(logic [1:0] rt, logic [31:0] k);
    in_beat_t b;
    b.req_type = rt;
    b.key = k;
    req_fifo.push_back(b);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (!(n_taken == n_queued && expected_beats.size() == 0)) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= THR_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INITIAL_POWER) shadow_init_pw = val & 4'hF;
    else shadow_thr = val & 9'h1FF;
  endtask

  function automatic logic [31:0] pick_key();
    int c;
    c = $urandom_range(9);
    if (c < 6) return key_pool[$urandom_range(15)];
    if (c == 6) return 32'($urandom_range(63));
    return $urandom;
  endfunction

  initial begin
    int pws [0:5];
    int thrs [0:5];
    int c;
    pws = '{2, 10, 0, 15, 1, 6};
    thrs = '{256, 511, 0, 1, 100, 200};
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = CFG_INITIAL_POWER;
    cfg_wdata = '0;
    taken = 0;
    errors = 0;
    cycles = 0;
    n_queued = 0;
    n_taken = 0;
    snd_idle = 6;
    rcv_idle = 65;
    shadow_bank = 0;
    shadow_power = 4;
    shadow_count = 0;
    shadow_init_pw = 4;
    shadow_thr = 154;
    wipe_bank(0);
    wipe_bank(1);
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: key extremes, duplicate, unused code, clear, reinit
    push_req(REQ_INSERT, 32'h0);
    push_req(REQ_INSERT, 32'h8000_0000);
    push_req(REQ_INSERT, 32'h7FFF_FFFF);
    push_req(REQ_INSERT, 32'hFFFF_FFFF);
    push_req(REQ_INSERT, 32'h1);
    push_req(REQ_INSERT, 32'h0);
    push_req(REQ_INSERT, 32'h8000_0000);
    push_req(2'd3, 32'hFFFF_FFFF);
    for (int i = 2; i < 12; i++) push_req(REQ_INSERT, 32'(i * 16));
    push_req(REQ_CLEAR, 32'h0);
    push_req(REQ_INSERT, 32'h1);
    push_req(REQ_REINIT, 32'h0);
    wait_idle();
    // zero threshold: grow to the maximum, then full
    write_reg(CFG_FILL_THRESHOLD, 0);
    write_reg(CFG_INITIAL_POWER, 0);
    push_req(REQ_REINIT, 32'h0);
    push_req(REQ_INSERT, 32'h5);
    push_req(REQ_INSERT, 32'h5);
    wait_idle();
    // oversize power, threshold above one
    write_reg(CFG_FILL_THRESHOLD, 300);
    write_reg(CFG_INITIAL_POWER, 12);
    push_req(REQ_REINIT, 32'h0);
    push_req(REQ_INSERT, 32'hDEAD_BEEF);
    wait_idle();

    // random segments under different settings and idle patterns
    for (int seg = 0; seg < 6; seg++) begin
      snd_idle = seg < 2 ? 6 : (seg < 4 ? 65 : 0);
      rcv_idle = seg < 2 ? 65 : (seg < 4 ? 6 : 0);
      write_reg(CFG_INITIAL_POWER, pws[seg]);
      write_reg(CFG_FILL_THRESHOLD, thrs[seg]);
      push_req(REQ_REINIT, $urandom);
      for (int i = 0; i < 105; i++) begin
        c = $urandom_range(99);
        if (c < 91) push_req(REQ_INSERT, pick_key());
        else if (c < 94) push_req(REQ_CLEAR, $urandom);
        else if (c < 97) push_req(REQ_REINIT, $urandom);
        else push_req(2'd3, $urandom);
        if (i == 50) wait_idle();
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
